FILE: sv/lsfs_pkg.sv
// Shared types and constants for the LCD serial frame sender.
`default_nettype none
package lsfs_pkg;

    // Frame layout: register select, read/write, then the byte
    localparam int FRAME_BITS   = 10;
    localparam int BYTE_BITS    = 8;
    localparam int HALF_W       = 16;
    localparam int HOLD_W       = HALF_W + 1;
    localparam int STATES       = 2 * FRAME_BITS + 2;
    localparam int STEP_W       = $clog2(STATES);
    localparam int BIT_IDX_W    = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd16;
    localparam logic [STEP_W-1:0] STEP_LEAD  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_DBL   = STEP_W'(STATES - 2);
    localparam logic [STEP_W-1:0] STEP_CLOSE = STEP_W'(STATES - 1);
    localparam logic              RW_WRITE   = 1'b0;

    typedef logic [FRAME_BITS-1:0] t_word;
    typedef logic [HALF_W-1:0]     t_half;
    typedef logic [HOLD_W-1:0]     t_hold;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: sv/lsfs_ifs.sv
// Channel interfaces: input beats, pin-state beats and configuration writes.
`default_nettype none
interface lsfs_in_if;
    logic                            valid;
    logic                            ready;
    logic                            is_data;
    logic [lsfs_pkg::BYTE_BITS-1:0]  payload_byte;
    modport source (output valid, output is_data, output payload_byte, input ready);
    modport sink   (input valid, input is_data, input payload_byte, output ready);
endinterface

interface lsfs_out_if;
    logic valid;
    logic ready;
    logic chip_select;
    logic serial_clock;
    logic serial_data;
    logic double_hold;
    logic frame_end;
    modport source (output valid, output chip_select, output serial_clock,
                    output serial_data, output double_hold, output frame_end,
                    input ready);
    modport sink   (input valid, input chip_select, input serial_clock,
                    input serial_data, input double_hold, input frame_end,
                    output ready);
endinterface

interface lsfs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lsfs_pkg::HALF_W-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/lsfs_front.sv
// Front part: accepts byte beats and packs them into frame words.
`default_nettype none
module lsfs_front (
    lsfs_in_if.sink          i_in,
    input  lsfs_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output lsfs_pkg::t_word  o_word
);

    // Take a beat whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // Build the frame word: register select, write bit, byte MSB first
    assign o_word = {i_in.is_data, lsfs_pkg::RW_WRITE, i_in.payload_byte};

endmodule
`default_nettype wire

FILE: sv/lsfs_queue.sv
// Short queue of frame words between the front and back parts.
`default_nettype none
module lsfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsfs_pkg::t_word   i_word,
    input  logic              i_pop,
    output lsfs_pkg::t_word   o_word,
    output lsfs_pkg::t_q_stat o_q_stat
);

    lsfs_pkg::t_word                   r_mem [lsfs_pkg::QUEUE_DEPTH];
    logic [lsfs_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [lsfs_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [lsfs_pkg::QCNT_W-1:0]       r_count;
    logic [lsfs_pkg::QCNT_W-1:0]       n_count;

    assign o_q_stat.empty = (r_count == '0);
    assign o_q_stat.full  = (r_count == lsfs_pkg::QCNT_W'(lsfs_pkg::QUEUE_DEPTH));
    assign o_word         = r_mem[r_rd_ptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lsfs_back.sv
// Back part: steps through the pin states of one frame and paces them.
`default_nettype none
module lsfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsfs_cfg_if.sink          i_cfg,
    input  lsfs_pkg::t_q_stat i_q_stat,
    input  lsfs_pkg::t_word   i_word,
    output logic              o_pop,
    lsfs_out_if.source        o_out
);

    lsfs_pkg::t_half                 r_half;
    logic [lsfs_pkg::STEP_W-1:0]     r_step;
    lsfs_pkg::t_hold                 r_timer;
    logic                            r_valid;
    logic                            r_cs;
    logic                            r_sck;
    logic                            r_sd;
    logic                            r_dbl;
    logic                            r_end;

    logic                            load;
    logic [lsfs_pkg::STEP_W-1:0]     step_m1;
    logic [lsfs_pkg::BIT_IDX_W-1:0]  bit_idx;
    logic                            cur_bit;
    logic                            n_cs;
    logic                            n_sck;
    logic                            n_sd;
    logic                            n_dbl;
    logic                            n_end;
    lsfs_pkg::t_hold                 half_eff;
    lsfs_pkg::t_hold                 hold;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    // Load the next state once a word is queued, the hold is over and the output slot frees
    assign load  = !i_q_stat.empty && (r_timer == '0) && (!r_valid || o_out.ready);
    assign o_pop = load && (r_step == lsfs_pkg::STEP_CLOSE);

    // Decode the step into pin levels
    assign step_m1 = r_step - 1'b1;
    assign bit_idx = lsfs_pkg::BIT_IDX_W'(lsfs_pkg::FRAME_BITS - 1)
                   - step_m1[lsfs_pkg::STEP_W-1:1];

    always_comb begin
        cur_bit = i_word[bit_idx];
        n_cs    = 1'b0;
        n_sck   = step_m1[0];
        n_sd    = cur_bit;
        n_dbl   = (r_step == lsfs_pkg::STEP_DBL);
        n_end   = 1'b0;
        if (r_step == lsfs_pkg::STEP_LEAD) begin
            n_sck = 1'b1;
            n_sd  = 1'b0;
        end else if (r_step == lsfs_pkg::STEP_CLOSE) begin
            n_cs  = 1'b1;
            n_sck = 1'b1;
            n_sd  = i_word[0];
            n_end = 1'b1;
        end
    end

    // Hold length: a zero half period counts as one
    assign half_eff = (r_half == '0) ? lsfs_pkg::HOLD_W'(1) : {1'b0, r_half};
    assign hold     = n_dbl ? {half_eff[lsfs_pkg::HOLD_W-2:0], 1'b0} : half_eff;

    // Control: config register, step counter, hold timer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= lsfs_pkg::HALF_RESET;
            r_step  <= lsfs_pkg::STEP_LEAD;
            r_timer <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_half <= i_cfg.data;
            end
            if (load) begin
                r_step  <= (r_step == lsfs_pkg::STEP_CLOSE) ? lsfs_pkg::STEP_LEAD
                                                            : r_step + 1'b1;
                r_timer <= hold - 1'b1;
                r_valid <= 1'b1;
            end else begin
                if (r_timer != '0) begin
                    r_timer <= r_timer - 1'b1;
                end
                if (o_out.ready) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // Hold the pin-state payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cs  <= n_cs;
            r_sck <= n_sck;
            r_sd  <= n_sd;
            r_dbl <= n_dbl;
            r_end <= n_end;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.chip_select  = r_cs;
    assign o_out.serial_clock = r_sck;
    assign o_out.serial_data  = r_sd;
    assign o_out.double_hold  = r_dbl;
    assign o_out.frame_end    = r_end;

endmodule
`default_nettype wire

FILE: sv/lcd_serial_frame_sender_unit.sv
// Top level of the LCD serial frame sender: front, word queue and back.
//
// Each input beat (command/data flag and one byte) becomes a 10-bit write
// frame that goes out as 22 pin-state beats: a lead-in with select low, a
// clock-low and a clock-high state for each bit (register select, write bit,
// byte MSB first), and a closing state that releases select. Each state is
// issued once the hold of the previous one is over (twice as long after the
// last clock-high state; a zero half period counts as one) and the output
// sink has taken the previous one, paced by the hold timer in the back part.
// A two-word queue lets the next byte be accepted while a frame is still
// being sent. The half period register is written through the
// configuration channel, which is always ready, and resets to 16.
`default_nettype none
module lcd_serial_frame_sender_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsfs_in_if.sink     i_in,
    lsfs_out_if.source  o_out,
    lsfs_cfg_if.sink    i_cfg
);

    lsfs_pkg::t_q_stat q_stat;
    lsfs_pkg::t_word   push_word;
    lsfs_pkg::t_word   head_word;
    logic              push;
    logic              pop;

    // Accept and pack byte beats
    lsfs_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_word   (push_word)
    );

    // Buffer frame words
    lsfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (push_word),
        .i_pop    (pop),
        .o_word   (head_word),
        .o_q_stat (q_stat)
    );

    // Send pin states
    lsfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .i_word   (head_word),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire
